// ===== design/usbmidi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmidi_pkg
// Shared types and constants for the usb midi endpoint finder.
// ----------------------------------------------------------------------------
package usbmidi_pkg;

	localparam int MPS_W       = 11;
	localparam int COUNT_W     = 17;
	localparam int TOTAL_W     = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [1:0] OUTCOME_UNDECIDED = 2'd0;
	localparam logic [1:0] OUTCOME_FOUND     = 2'd1;
	localparam logic [1:0] OUTCOME_FAILED    = 2'd2;

	localparam logic [7:0] DT_CONFIG        = 8'h02;
	localparam logic [7:0] DT_INTERFACE     = 8'h04;
	localparam logic [7:0] DT_ENDPOINT      = 8'h05;
	localparam logic [7:0] CLASS_AUDIO      = 8'h01;
	localparam logic [7:0] SUBCLASS_MIDI    = 8'h03;
	localparam logic [1:0] XFER_BULK        = 2'd2;
	localparam logic [1:0] XFER_INTERRUPT   = 2'd3;
	localparam int         EP_DIR_BIT       = 7;
	localparam logic [7:0] MIN_DESC_LEN     = 8'd2;
	localparam logic [7:0] MIN_CONFIG_LEN   = 8'd9;
	localparam logic [7:0] MIN_IFACE_LEN    = 8'd9;
	localparam logic [7:0] MIN_EP_LEN       = 8'd7;
	localparam int         HEADER_BYTES     = 4;

	typedef struct packed {
		logic [7:0] desc_byte;
		logic       last_byte;
	} desc_item_t;

	typedef struct packed {
		logic             found;
		logic [7:0]       interface_number;
		logic [7:0]       alt_setting;
		logic [7:0]       in_endpoint_address;
		logic [MPS_W-1:0] in_max_packet;
		logic [7:0]       out_endpoint_address;
		logic [MPS_W-1:0] out_max_packet;
	} res_item_t;

endpackage

// ===== design/usbmidi_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbmidi_walk
// Descriptor walker: header check, descriptor walk, candidate tracking and
// the result for the final byte, one byte per step.
// ----------------------------------------------------------------------------
module usbmidi_walk (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  usbmidi_pkg::desc_item_t item,
	output usbmidi_pkg::res_item_t  result
);
	import usbmidi_pkg::*;

	logic [COUNT_W-1:0] bytes_seen_q, bytes_seen_d;
	logic [7:0]         hdr_len_q, hdr_len_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [COUNT_W-1:0] next_off_q, next_off_d;
	logic [7:0]         cur_len_q, cur_len_d;
	logic [7:0]         cur_type_q, cur_type_d;
	logic [23:0]        latches_q, latches_d;
	logic               midi_q, midi_d;
	logic               in_ok_q, in_ok_d;
	logic               out_ok_q, out_ok_d;
	logic [7:0]         cand_if_q, cand_if_d;
	logic [7:0]         cand_alt_q, cand_alt_d;
	logic [7:0]         cand_in_addr_q, cand_in_addr_d;
	logic [MPS_W-1:0]   cand_in_mps_q, cand_in_mps_d;
	logic [7:0]         cand_out_addr_q, cand_out_addr_d;
	logic [MPS_W-1:0]   cand_out_mps_q, cand_out_mps_d;
	logic [1:0]         outcome_q, outcome_d;

	logic [7:0]         b;
	logic [COUNT_W:0]   total_ext;
	logic [COUNT_W:0]   start_p2;
	logic [COUNT_W:0]   desc_end;
	logic [COUNT_W-1:0] rel;
	logic               walk_on;
	logic [TOTAL_W-1:0] total_new;
	logic [7:0]         ep_addr;
	logic [1:0]         ep_xfer;
	logic [MPS_W-1:0]   ep_mps;
	logic               ok;
	logic               hit;

	assign b         = item.desc_byte;
	assign total_ext = {2'b00, total_q};
	assign start_p2  = {1'b0, next_off_q} + (COUNT_W+1)'(2);
	assign desc_end  = {1'b0, next_off_q} + {{(COUNT_W+1-8){1'b0}}, cur_len_q};
	assign rel       = bytes_seen_q - next_off_q;
	assign walk_on   = (start_p2 <= total_ext) && (bytes_seen_q >= next_off_q);
	assign ep_addr   = latches_q[7:0];
	assign ep_xfer   = latches_q[9:8];
	assign ep_mps    = {b[2:0], latches_q[23:16]};

	always_comb begin
		logic stop;
		stop            = 1'b0;
		total_new       = {b, total_q[7:0]};
		hdr_len_d       = hdr_len_q;
		total_d         = total_q;
		next_off_d      = next_off_q;
		cur_len_d       = cur_len_q;
		cur_type_d      = cur_type_q;
		latches_d       = latches_q;
		midi_d          = midi_q;
		in_ok_d         = in_ok_q;
		out_ok_d        = out_ok_q;
		cand_if_d       = cand_if_q;
		cand_alt_d      = cand_alt_q;
		cand_in_addr_d  = cand_in_addr_q;
		cand_in_mps_d   = cand_in_mps_q;
		cand_out_addr_d = cand_out_addr_q;
		cand_out_mps_d  = cand_out_mps_q;
		outcome_d       = outcome_q;
		if (outcome_q == OUTCOME_UNDECIDED) begin
			if (bytes_seen_q == COUNT_W'(0)) begin
				hdr_len_d = b;
			end else if (bytes_seen_q == COUNT_W'(1)) begin
				cur_type_d = b;
			end else if (bytes_seen_q == COUNT_W'(2)) begin
				total_d = {8'd0, b};
			end else if (bytes_seen_q == COUNT_W'(3)) begin
				total_d = total_new;
				if (hdr_len_q < MIN_CONFIG_LEN || cur_type_q != DT_CONFIG ||
						total_new < {8'd0, hdr_len_q}) begin
					outcome_d = OUTCOME_FAILED;
				end else begin
					next_off_d = {{(COUNT_W-8){1'b0}}, hdr_len_q};
				end
				cur_type_d = 8'd0;
			end else if (walk_on) begin
				if (rel == COUNT_W'(0)) begin
					cur_len_d = b;
				end else begin
					if (rel == COUNT_W'(1)) begin
						cur_type_d = b;
						if (cur_len_q < MIN_DESC_LEN || desc_end > total_ext) begin
							outcome_d = OUTCOME_FAILED;
							stop      = 1'b1;
						end else if (b == DT_INTERFACE) begin
							if (cur_len_q < MIN_IFACE_LEN) begin
								outcome_d = OUTCOME_FAILED;
								stop      = 1'b1;
							end else if (midi_q && in_ok_q && out_ok_q) begin
								outcome_d = OUTCOME_FOUND;
								stop      = 1'b1;
							end else begin
								midi_d          = 1'b0;
								in_ok_d         = 1'b0;
								out_ok_d        = 1'b0;
								cand_if_d       = 8'd0;
								cand_alt_d      = 8'd0;
								cand_in_addr_d  = 8'd0;
								cand_in_mps_d   = '0;
								cand_out_addr_d = 8'd0;
								cand_out_mps_d  = '0;
								latches_d       = '0;
							end
						end else if (b == DT_ENDPOINT && midi_q) begin
							if (cur_len_q < MIN_EP_LEN) begin
								outcome_d = OUTCOME_FAILED;
								stop      = 1'b1;
							end else begin
								latches_d = '0;
							end
						end
					end else if (cur_type_q == DT_INTERFACE) begin
						if (rel == COUNT_W'(2)) begin
							cand_if_d = b;
						end else if (rel == COUNT_W'(3)) begin
							cand_alt_d = b;
						end else if (rel == COUNT_W'(5)) begin
							latches_d = {16'd0, b};
						end else if (rel == COUNT_W'(6)) begin
							midi_d = (latches_q[7:0] == CLASS_AUDIO) && (b == SUBCLASS_MIDI);
						end
					end else if (cur_type_q == DT_ENDPOINT && midi_q) begin
						if (rel == COUNT_W'(2)) begin
							latches_d[7:0] = b;
						end else if (rel == COUNT_W'(3)) begin
							latches_d[15:8] = b;
						end else if (rel == COUNT_W'(4)) begin
							latches_d[23:16] = b;
						end else if (rel == COUNT_W'(5)) begin
							if ((ep_xfer == XFER_BULK || ep_xfer == XFER_INTERRUPT) &&
									ep_mps != '0) begin
								if (ep_addr[EP_DIR_BIT]) begin
									cand_in_addr_d = ep_addr;
									cand_in_mps_d  = ep_mps;
									in_ok_d        = 1'b1;
								end else begin
									cand_out_addr_d = ep_addr;
									cand_out_mps_d  = ep_mps;
									out_ok_d        = 1'b1;
								end
							end
						end
					end
					if (!stop && ({1'b0, rel} + (COUNT_W+1)'(1)) ==
							{{(COUNT_W+1-8){1'b0}}, cur_len_q}) begin
						next_off_d = desc_end[COUNT_W-1:0];
					end
				end
			end
		end
		bytes_seen_d = (bytes_seen_q == COUNT_MAX) ? bytes_seen_q
			: bytes_seen_q + COUNT_W'(1);
	end

	assign ok  = (outcome_d != OUTCOME_FAILED) && (bytes_seen_d >= COUNT_W'(HEADER_BYTES)) &&
		({1'b0, total_d} <= bytes_seen_d);
	assign hit = ok && ((outcome_d == OUTCOME_FOUND) || (midi_d && in_ok_d && out_ok_d));

	always_comb begin
		result = '0;
		if (hit) begin
			result.found                = 1'b1;
			result.interface_number     = cand_if_d;
			result.alt_setting          = cand_alt_d;
			result.in_endpoint_address  = cand_in_addr_d;
			result.in_max_packet        = cand_in_mps_d;
			result.out_endpoint_address = cand_out_addr_d;
			result.out_max_packet       = cand_out_mps_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q    <= '0;
			hdr_len_q       <= '0;
			total_q         <= '0;
			next_off_q      <= '0;
			cur_len_q       <= '0;
			cur_type_q      <= '0;
			latches_q       <= '0;
			midi_q          <= 1'b0;
			in_ok_q         <= 1'b0;
			out_ok_q        <= 1'b0;
			cand_if_q       <= '0;
			cand_alt_q      <= '0;
			cand_in_addr_q  <= '0;
			cand_in_mps_q   <= '0;
			cand_out_addr_q <= '0;
			cand_out_mps_q  <= '0;
			outcome_q       <= OUTCOME_UNDECIDED;
		end else if (step) begin
			if (item.last_byte) begin
				bytes_seen_q    <= '0;
				hdr_len_q       <= '0;
				total_q         <= '0;
				next_off_q      <= '0;
				cur_len_q       <= '0;
				cur_type_q      <= '0;
				latches_q       <= '0;
				midi_q          <= 1'b0;
				in_ok_q         <= 1'b0;
				out_ok_q        <= 1'b0;
				cand_if_q       <= '0;
				cand_alt_q      <= '0;
				cand_in_addr_q  <= '0;
				cand_in_mps_q   <= '0;
				cand_out_addr_q <= '0;
				cand_out_mps_q  <= '0;
				outcome_q       <= OUTCOME_UNDECIDED;
			end else begin
				bytes_seen_q    <= bytes_seen_d;
				hdr_len_q       <= hdr_len_d;
				total_q         <= total_d;
				next_off_q      <= next_off_d;
				cur_len_q       <= cur_len_d;
				cur_type_q      <= cur_type_d;
				latches_q       <= latches_d;
				midi_q          <= midi_d;
				in_ok_q         <= in_ok_d;
				out_ok_q        <= out_ok_d;
				cand_if_q       <= cand_if_d;
				cand_alt_q      <= cand_alt_d;
				cand_in_addr_q  <= cand_in_addr_d;
				cand_in_mps_q   <= cand_in_mps_d;
				cand_out_addr_q <= cand_out_addr_d;
				cand_out_mps_q  <= cand_out_mps_d;
				outcome_q       <= outcome_d;
			end
		end
	end

	// rearm after the final byte
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> bytes_seen_q == '0 && outcome_q == OUTCOME_UNDECIDED)
		else $error("walker did not rearm after final byte");

	// an early decision sticks until the final byte
	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		outcome_q == OUTCOME_FOUND && !(step && item.last_byte) |=> outcome_q == OUTCOME_FOUND)
		else $error("found outcome lost before final byte");

	// walk never starts a descriptor past the declared total
	a_offset_in_total: assert property (@(posedge clk) disable iff (!arst_n)
		outcome_q != OUTCOME_FAILED |-> next_off_q <= {1'b0, total_q})
		else $error("descriptor offset beyond declared total");

	// a found result needs both endpoints with nonzero sizes
	a_found_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		result.found |-> result.in_max_packet != '0 && result.out_max_packet != '0 &&
			result.in_endpoint_address[EP_DIR_BIT] && !result.out_endpoint_address[EP_DIR_BIT])
		else $error("found result with missing endpoint");

endmodule

// ===== design/usb_midi_endpoint_finder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_midi_endpoint_finder_top
// Finds the first usb midi streaming interface with bulk or interrupt in and
// out endpoints in a configuration descriptor streamed one byte a transaction.
// ----------------------------------------------------------------------------
// the final byte is registered in the input stage, then its result is registered onto res
// throughput: one byte per cycle, but a final byte waits while a result is pending and res_ready is low
// res_ready back-pressure stalls only bytes that end a buffer
// reset: arst_n clears the input stage valid, result stage valid and all walker state
// ----------------------------------------------------------------------------
module usb_midi_endpoint_finder_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    desc_valid,
	output logic                    desc_ready,
	input  usbmidi_pkg::desc_item_t desc,
	output logic                    res_valid,
	input  logic                    res_ready,
	output usbmidi_pkg::res_item_t  res
);
	import usbmidi_pkg::*;

	logic       valid_s1;
	desc_item_t item_s1;
	logic       advance;
	res_item_t  result;
	logic       res_valid_q;
	res_item_t  res_q;

	assign advance    = valid_s1 && (!item_s1.last_byte || !res_valid_q || res_ready);
	assign desc_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc_ready) begin
			valid_s1 <= desc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			item_s1 <= desc;
		end
	end

	usbmidi_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a final byte that steps the walker always shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> res_valid_q)
		else $error("final byte produced no result");

	// a stalled final byte never overwrites a pending result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready && valid_s1 && item_s1.last_byte |-> !advance)
		else $error("pending result overwritten");

	// a byte that ends no buffer never waits on the output side
	a_mid_bytes_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.last_byte |-> advance && desc_ready)
		else $error("mid-buffer byte stalled");

endmodule
